// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/amf0ol_pkg.sv -----
// package: types and constants of the amf0 object string lookup
`timescale 1ns / 1ps

package amf0ol_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES) + 1;

    // amf0 markers
    localparam logic [7:0] MRK_NUMBER = 8'h00;
    localparam logic [7:0] MRK_BOOL   = 8'h01;
    localparam logic [7:0] MRK_STRING = 8'h02;
    localparam logic [7:0] MRK_OBJECT = 8'h03;
    localparam logic [7:0] MRK_NULL   = 8'h05;

    localparam logic [15:0] NUMBER_BYTES = 16'd8;
    localparam logic [15:0] BOOL_BYTES   = 16'd1;

    // outcome codes
    localparam logic [1:0] OUT_FOUND = 2'd0;
    localparam logic [1:0] OUT_NONE  = 2'd1;
    localparam logic [1:0] OUT_TRUNC = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_KEY_WORD_0 = 2'd1;
    localparam logic [1:0] CFG_KEY_WORD_1 = 2'd2;

    typedef enum logic [9:0] {
        PH_SEEK    = 10'b00_0000_0001,
        PH_KLEN_HI = 10'b00_0000_0010,
        PH_KLEN_LO = 10'b00_0000_0100,
        PH_KEY     = 10'b00_0000_1000,
        PH_MARKER  = 10'b00_0001_0000,
        PH_SLEN_HI = 10'b00_0010_0000,
        PH_SLEN_LO = 10'b00_0100_0000,
        PH_SVAL    = 10'b00_1000_0000,
        PH_SKIP    = 10'b01_0000_0000,
        PH_CLOSED  = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [4:0]  key_length;
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
    } t_key_cfg;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_valid;
        logic       done_res;
        logic [1:0] outcome;
    } t_result;

endpackage

// ----- design/amf0_object_string_lookup.sv -----
// top level: amf0 object property lookup, emits the matching string value
// an accepted byte's result item is held in the output register from the next cycle on
// throughput: one byte per cycle; a byte is taken whenever the output register is
//   empty or being drained in the same cycle
// reset: synchronous active-low i_rst_n clears the walker to seek-object and the
//   key registers to zero; no clearing pass, ready right after reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amf0_object_string_lookup
    import amf0ol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // payload byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_value_byte,
    output logic        o_value_valid,
    output logic        o_done_res,
    output logic [1:0]  o_outcome
);

    t_key_cfg key_cfg;
    t_result  step_res;
    t_result  out_res;
    logic     in_accept;
    logic     can_load;

    // wanted key and its length
    amf0ol_key_regs u_key_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_key      (key_cfg)
    );

    // an item moves in only when the result register can take its result
    assign o_in_ready = can_load;
    assign in_accept  = i_in_valid && can_load;

    // walker: one step per accepted byte, state updates on accept
    amf0ol_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_key       (key_cfg),
        .o_result    (step_res)
    );

    // result register, refilled in the same cycle it drains
    amf0ol_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_result    (step_res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_can_load  (can_load),
        .o_result    (out_res)
    );

    assign o_value_byte  = out_res.value_byte;
    assign o_value_valid = out_res.value_valid;
    assign o_done_res    = out_res.done_res;
    assign o_outcome     = out_res.outcome;

    // an emitted value byte never closes with "not found"
    `AST_IMPLY(a_vbyte_not_none, i_clk, i_rst_n, o_out_valid && o_value_valid, o_outcome != OUT_NONE)
    // outcome stays zero unless the item closes the search
    `AST_IMPLY(a_outcome_idle, i_clk, i_rst_n, o_out_valid && !o_done_res, o_outcome == OUT_FOUND)
    // value byte is zero unless it belongs to the match
    `AST_IMPLY(a_vbyte_zero, i_clk, i_rst_n, o_out_valid && !o_value_valid, o_value_byte == 8'd0)
    // an empty result register always takes a byte
    `AST_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // an accepted byte always yields a result item
    `AST_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

endmodule

// ----- design/amf0ol_key_regs.sv -----
// configuration registers holding the wanted key
`timescale 1ns / 1ps

module amf0ol_key_regs
    import amf0ol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output t_key_cfg    o_key
);

    t_key_cfg r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_LENGTH: begin
                    r_key.key_length <= i_cfg_data[4:0];
                end
                CFG_KEY_WORD_0: begin
                    r_key.key_word_0 <= i_cfg_data;
                end
                CFG_KEY_WORD_1: begin
                    r_key.key_word_1 <= i_cfg_data;
                end
                default: begin
                    r_key <= r_key;
                end
            endcase
        end
    end

    assign o_key = r_key;

endmodule

// ----- design/amf0ol_parser.sv -----
// byte-wise amf0 walker: state registers and the per-byte step logic
`timescale 1ns / 1ps

module amf0ol_parser
    import amf0ol_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  t_key_cfg   i_key,
    output t_result    o_result
);

    t_phase                 r_phase,   n_phase;
    logic [15:0]            r_count,   n_count;
    logic [7:0]             r_len_hi,  n_len_hi;
    logic                   r_key_eq,  n_key_eq;
    logic [KEY_IDX_W-1:0]   r_key_idx, n_key_idx;

    logic [0:MAX_KEY_BYTES-1][7:0] key_bytes;
    logic [15:0]            len_word;
    logic [15:0]            count_dec;
    logic [7:0]             wanted;
    t_result                res;

    assign key_bytes = {i_key.key_word_0, i_key.key_word_1};
    assign len_word  = {r_len_hi, i_data_byte};
    assign count_dec = r_count - 16'd1;
    assign wanted    = key_bytes[r_key_idx[KEY_IDX_W-2:0]];

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_len_hi  = r_len_hi;
        n_key_eq  = r_key_eq;
        n_key_idx = r_key_idx;
        res       = '0;

        case (r_phase)
            PH_SEEK: begin
                if (i_data_byte == MRK_OBJECT) n_phase = PH_KLEN_HI;
            end
            PH_KLEN_HI: begin
                n_len_hi = i_data_byte;
                n_phase  = PH_KLEN_LO;
            end
            PH_KLEN_LO: begin
                if (len_word == 16'd0) begin
                    n_phase      = PH_CLOSED;
                    res.done_res = 1'b1;
                    res.outcome  = OUT_NONE;
                end else begin
                    n_count   = len_word;
                    n_key_idx = '0;
                    n_key_eq  = (i_key.key_length <= 5'(MAX_KEY_BYTES)) &&
                                (len_word == {11'd0, i_key.key_length});
                    n_phase   = PH_KEY;
                end
            end
            PH_KEY: begin
                // top index bit set means past the longest key we hold
                if (r_key_eq && (r_key_idx[KEY_IDX_W-1] || wanted != i_data_byte))
                    n_key_eq = 1'b0;
                if (!r_key_idx[KEY_IDX_W-1]) n_key_idx = r_key_idx + KEY_IDX_W'(1);
                n_count = count_dec;
                if (count_dec == 16'd0) n_phase = PH_MARKER;
            end
            PH_MARKER: begin
                case (i_data_byte)
                    MRK_STRING: begin
                        n_phase = PH_SLEN_HI;
                    end
                    MRK_NUMBER: begin
                        n_count = NUMBER_BYTES;
                        n_phase = PH_SKIP;
                    end
                    MRK_BOOL: begin
                        n_count = BOOL_BYTES;
                        n_phase = PH_SKIP;
                    end
                    MRK_NULL: begin
                        n_phase = PH_KLEN_HI;
                    end
                    default: begin
                        n_phase      = PH_CLOSED;
                        res.done_res = 1'b1;
                        res.outcome  = OUT_NONE;
                    end
                endcase
            end
            PH_SLEN_HI: begin
                n_len_hi = i_data_byte;
                n_phase  = PH_SLEN_LO;
            end
            PH_SLEN_LO: begin
                if (len_word == 16'd0) begin
                    if (r_key_eq) begin
                        n_phase      = PH_CLOSED;
                        res.done_res = 1'b1;
                        res.outcome  = OUT_FOUND;
                    end else begin
                        n_phase = PH_KLEN_HI;
                    end
                end else begin
                    n_count = len_word;
                    n_phase = PH_SVAL;
                end
            end
            PH_SVAL: begin
                if (r_key_eq) begin
                    res.value_byte  = i_data_byte;
                    res.value_valid = 1'b1;
                end
                n_count = count_dec;
                if (count_dec == 16'd0) begin
                    if (r_key_eq) begin
                        n_phase      = PH_CLOSED;
                        res.done_res = 1'b1;
                        res.outcome  = OUT_FOUND;
                    end else begin
                        n_phase = PH_KLEN_HI;
                    end
                end
            end
            PH_SKIP: begin
                n_count = count_dec;
                if (count_dec == 16'd0) n_phase = PH_KLEN_HI;
            end
            PH_CLOSED: begin
                n_phase = PH_CLOSED;
            end
            default: begin
                n_phase = PH_CLOSED;
            end
        endcase

        // end of payload: close if still open, then start afresh
        if (i_last_byte) begin
            if (n_phase != PH_CLOSED) begin
                res.done_res = 1'b1;
                res.outcome  = (n_phase == PH_SVAL && n_key_eq) ? OUT_TRUNC : OUT_NONE;
            end
            n_phase   = PH_SEEK;
            n_count   = '0;
            n_len_hi  = '0;
            n_key_eq  = 1'b1;
            n_key_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEEK;
            r_count   <= '0;
            r_len_hi  <= '0;
            r_key_eq  <= 1'b1;
            r_key_idx <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_len_hi  <= n_len_hi;
            r_key_eq  <= n_key_eq;
            r_key_idx <= n_key_idx;
        end
    end

    assign o_result = res;

endmodule

// ----- design/amf0ol_out_reg.sv -----
// result register between the walker and the output channel
`timescale 1ns / 1ps

module amf0ol_out_reg
    import amf0ol_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_can_load,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_can_load = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load)           n_valid = 1'b1;
        else if (i_out_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_data <= i_result;
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_data;

endmodule

// ----- test/amf0_object_string_lookup_tb.sv -----
// testbench: amf0 object string lookup checked against a byte-level walk predictor
`timescale 1ns / 1ps

module amf0_object_string_lookup_tb;
    import amf0ol_pkg::*;

    // clock, reset and dut ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_value_byte;
    logic        o_value_valid;
    logic        o_done_res;
    logic [1:0]  o_outcome;

    // predictor copy of the key registers
    logic [4:0]  key_len_reg;
    logic [63:0] key_w0_reg;
    logic [63:0] key_w1_reg;

    // predictor copy of the walker state
    t_phase      walk_phase;
    logic [15:0] bytes_left;
    logic [7:0]  len_high;
    logic        key_match;
    logic [15:0] key_pos;
    logic        search_done;

    t_result     lookup_items_q[$];     // expected result items, oldest first
    logic [7:0]  frame[$];              // payload being built for sending
    int unsigned items_sent   = 0;
    int unsigned mismatch_count = 0;
    bit          gaps_on      = 1'b0;   // random idling on both channels

    amf0_object_string_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value_byte  (o_value_byte),
        .o_value_valid (o_value_valid),
        .o_done_res    (o_done_res),
        .o_outcome     (o_outcome)
    );

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the dut hangs a handshake
    initial begin
        #4_000_000;
        $display("** amf0_object_string_lookup: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // wanted key byte, position wraps every 16 bytes like the register pair
    function automatic logic [7:0] key_byte(input int unsigned pos);
        logic [63:0] w;
        w = pos[3] ? key_w1_reg : key_w0_reg;
        return w[8 * (7 - pos[2:0]) +: 8];
    endfunction

    function automatic void restart_walk();
        walk_phase  = PH_SEEK;
        bytes_left  = '0;
        len_high    = '0;
        key_match   = 1'b1;
        key_pos     = '0;
        search_done = 1'b0;
    endfunction

    // marks the search closed with the given outcome
    function automatic void close_search(inout t_result r, input logic [1:0] code);
        walk_phase  = PH_CLOSED;
        search_done = 1'b1;
        r.done_res  = 1'b1;
        r.outcome   = code;
    endfunction

    // one payload byte through the walker, returns the result item it causes
    function automatic t_result walk_amf0_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic [15:0] n;
        r = '0;
        n = {len_high, b};
        case (walk_phase)
            PH_SEEK: begin
                if (b == MRK_OBJECT) walk_phase = PH_KLEN_HI;
            end
            PH_KLEN_HI, PH_SLEN_HI: begin
                len_high   = b;
                walk_phase = (walk_phase == PH_KLEN_HI) ? PH_KLEN_LO : PH_SLEN_LO;
            end
            PH_KLEN_LO: begin
                // a zero key length is the object end marker
                if (n == 16'd0) begin
                    close_search(r, OUT_NONE);
                end else begin
                    bytes_left = n;
                    key_pos    = '0;
                    key_match  = (key_len_reg <= MAX_KEY_BYTES) && (n == {11'd0, key_len_reg});
                    walk_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                if (key_match && (key_pos >= MAX_KEY_BYTES || key_byte(key_pos) != b))
                    key_match = 1'b0;
                key_pos    = key_pos + 16'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) walk_phase = PH_MARKER;
            end
            PH_MARKER: begin
                case (b)
                    MRK_STRING: walk_phase = PH_SLEN_HI;
                    MRK_NUMBER: begin
                        bytes_left = NUMBER_BYTES;
                        walk_phase = PH_SKIP;
                    end
                    MRK_BOOL: begin
                        bytes_left = BOOL_BYTES;
                        walk_phase = PH_SKIP;
                    end
                    MRK_NULL: walk_phase = PH_KLEN_HI;
                    default:  close_search(r, OUT_NONE);
                endcase
            end
            PH_SLEN_LO: begin
                if (n != 16'd0) begin
                    bytes_left = n;
                    walk_phase = PH_SVAL;
                end else if (key_match) begin
                    close_search(r, OUT_FOUND);
                end else begin
                    walk_phase = PH_KLEN_HI;
                end
            end
            PH_SVAL: begin
                if (key_match) begin
                    r.value_byte  = b;
                    r.value_valid = 1'b1;
                end
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    if (key_match) close_search(r, OUT_FOUND);
                    else walk_phase = PH_KLEN_HI;
                end
            end
            PH_SKIP: begin
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) walk_phase = PH_KLEN_HI;
            end
            default: walk_phase = PH_CLOSED;
        endcase
        // the last byte closes an open search and rearms the walker
        if (last) begin
            if (!search_done) begin
                r.done_res = 1'b1;
                r.outcome  = (walk_phase == PH_SVAL && key_match) ? OUT_TRUNC : OUT_NONE;
            end
            restart_walk();
        end
        return r;
    endfunction

    initial begin
        key_len_reg = '0;
        key_w0_reg  = '0;
        key_w1_reg  = '0;
        restart_walk();
    end

    // ------------------------------------------------------------------
    // monitors and checking
    // ------------------------------------------------------------------

    // every accepted payload byte yields exactly one expected item
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            lookup_items_q.push_back(walk_amf0_byte(i_data_byte, i_last_byte));
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= 21);
    end

    function automatic void compare_field(input string fname, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endfunction

    // each accepted result item against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lookup_items_q.size() == 0) begin
                $display("%0t: result item with none expected (byte %0h valid %0b done %0b outcome %0d)",
                         $time, o_value_byte, o_value_valid, o_done_res, o_outcome);
                mismatch_count++;
            end else begin
                want = lookup_items_q.pop_front();
                compare_field("value_byte", want.value_byte, o_value_byte);
                compare_field("value_valid", 8'(want.value_valid), 8'(o_value_valid));
                compare_field("done_res", 8'(want.done_res), 8'(o_done_res));
                compare_field("outcome", 8'(want.outcome), 8'(o_outcome));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one payload byte; valid holds until the dut takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    endtask

    // stop sending and let every expected item come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (lookup_items_q.size() != 0) @(posedge i_clk);
        // plus margin after the last item is checked
        repeat (2) @(posedge i_clk);
    endtask

    // all three key registers, only once the dut has gone idle
    task automatic write_key(input logic [4:0] len, input logic [127:0] key);
        logic [63:0] noise;
        wait_for_results();
        noise = {$urandom, $urandom};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEY_LENGTH;
        i_cfg_data <= {noise[63:5], len};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_WORD_0;
        i_cfg_data <= key[127:64];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_WORD_1;
        i_cfg_data <= key[63:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        key_len_reg = len;
        key_w0_reg  = key[127:64];
        key_w1_reg  = key[63:0];
    endtask

    function automatic void put_len(input int unsigned n);
        frame.push_back(n[15:8]);
        frame.push_back(n[7:0]);
    endfunction

    function automatic logic [7:0] not_object_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == MRK_OBJECT) ? 8'hff : b;
    endfunction

    // one key/value pair; most keys aim at the wanted key or just miss it
    function automatic void add_property();
        int unsigned pick, klen, vlen;
        int          flip;
        bit          aim;
        logic [7:0]  kb;
        pick = $urandom_range(0, 99);
        aim  = (key_len_reg != 0) && (pick >= 40);
        klen = (pick == 0) ? $urandom_range(256, 300) : $urandom_range(1, 20);
        flip = -1;
        if (aim) begin
            klen = key_len_reg;
            if (pick < 52) flip = $urandom_range(0, klen - 1);
            else if (pick < 56 && klen > 1) klen = klen - 1;
        end
        put_len(klen);
        for (int i = 0; i < klen; i++) begin
            kb = aim ? key_byte(i) : 8'($urandom_range(0, 255));
            if (i == flip) kb = kb ^ (8'd1 << $urandom_range(0, 7));
            frame.push_back(kb);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            frame.push_back(MRK_STRING);
            vlen = (pick < 5) ? 0 : (pick < 7) ? $urandom_range(200, 300) : $urandom_range(1, 10);
            put_len(vlen);
            repeat (vlen) frame.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 62) begin
            frame.push_back(MRK_NUMBER);
            repeat (NUMBER_BYTES) frame.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 74) begin
            frame.push_back(MRK_BOOL);
            frame.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            frame.push_back(MRK_NULL);
        end else begin
            kb = 8'($urandom_range(0, 255));
            if (kb inside {MRK_NUMBER, MRK_BOOL, MRK_STRING, MRK_NULL}) kb = MRK_OBJECT;
            frame.push_back(kb);
        end
    endfunction

    // mostly well-formed objects, some cut short, padded or without a marker
    function automatic void build_random_frame();
        int unsigned cut;
        frame.delete();
        repeat ($urandom_range(0, 3)) frame.push_back(not_object_byte());
        if ($urandom_range(0, 99) < 5) begin
            frame.push_back(not_object_byte());
            return;
        end
        frame.push_back(MRK_OBJECT);
        repeat ($urandom_range(1, 4)) add_property();
        if ($urandom_range(0, 99) < 15) put_len(0);
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 20) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // key "ab" for the directed cases
    localparam logic [127:0] KEY_AB = {8'h61, 8'h62, 112'd0};

    // payload that never opens an object
    task automatic test_no_object();
        write_key(5'd2, KEY_AB);
        frame = '{8'h7f, 8'h80, 8'h00};
        send_frame();
    endtask

    // matching key with bool and null values is skipped, then a string matches;
    // a wrong-length key with a number sits in between; one byte after closing
    task automatic test_skip_then_match();
        frame = '{8'h03,
                  8'h00, 8'h02, 8'h61, 8'h62, 8'h01, 8'hff,
                  8'h00, 8'h02, 8'h61, 8'h63, 8'h02, 8'h00, 8'h01, 8'h7a,
                  8'h00, 8'h02, 8'h61, 8'h62, 8'h05,
                  8'h00, 8'h01, 8'h61, 8'h00,
                  8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7e, 8'hfe,
                  8'h00, 8'h02, 8'h61, 8'h62, 8'h02, 8'h00, 8'h02, 8'h68, 8'h69,
                  8'h71};
        send_frame();
    endtask

    // zero key length, unknown marker, empty matching string
    task automatic test_search_enders();
        frame = '{8'h03, 8'h00, 8'h00, 8'h11};
        send_frame();
        frame = '{8'h03, 8'h00, 8'h01, 8'h61, 8'h07, 8'h22};
        send_frame();
        frame = '{8'h03, 8'h00, 8'h02, 8'h61, 8'h62, 8'h02, 8'h00, 8'h00, 8'h33};
        send_frame();
    endtask

    // payload ends inside the matched string, inside a value, inside a key
    task automatic test_truncation();
        frame = '{8'h03, 8'h00, 8'h02, 8'h61, 8'h62, 8'h02, 8'h00, 8'h05, 8'h68, 8'h65};
        send_frame();
        frame = '{8'h03, 8'h00, 8'h02, 8'h61, 8'h62, 8'h01};
        send_frame();
        frame = '{8'h03, 8'h00, 8'h02, 8'h61};
        send_frame();
    endtask

    // full 16-byte key, too-long key length, zero key length
    task automatic test_key_extremes();
        write_key(5'd16, 128'hff00_a55a_0102_0408_1020_4080_7f80_fe01);
        frame = '{8'h03};
        put_len(16);
        for (int i = 0; i < 16; i++) frame.push_back(key_byte(i));
        frame.push_back(MRK_STRING);
        put_len(1);
        frame.push_back(8'h00);
        send_frame();

        // a key longer than the register pair never matches
        write_key(5'd31, {$urandom, $urandom, $urandom, $urandom});
        frame = '{8'h03};
        put_len(31);
        for (int i = 0; i < 31; i++) frame.push_back(key_byte(i));
        frame.push_back(MRK_STRING);
        put_len(1);
        frame.push_back(8'h41);
        send_frame();

        write_key(5'd0, '1);
        frame = '{8'h03, 8'h00, 8'h01, 8'hff, 8'h02, 8'h00, 8'h01, 8'h42};
        send_frame();
    endtask

    // random objects over a series of key settings; first setting runs without gaps
    task automatic test_random_payloads();
        int unsigned pick;
        logic [4:0]  len;
        gaps_on = 1'b0;
        while (items_sent < 700) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       len = 5'd0;
                1:       len = 5'($urandom_range(17, 31));
                2:       len = 5'd16;
                default: len = 5'($urandom_range(1, 16));
            endcase
            // write_key drains everything first, so the sender pauses here
            write_key(len, {$urandom, $urandom, $urandom, $urandom});
            repeat ($urandom_range(4, 10)) begin
                if (items_sent >= 700) break;
                build_random_frame();
                send_frame();
            end
            gaps_on = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_KEY_LENGTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on = 1'b1;
        test_no_object();
        test_skip_then_match();
        test_search_enders();
        test_truncation();
        test_key_extremes();
        test_random_payloads();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && lookup_items_q.size() == 0) begin
            $display("** amf0_object_string_lookup: PASSED **");
        end else begin
            $display("** amf0_object_string_lookup: FAILED **");
        end
        $finish;
    end

endmodule

// ----- amf0_object_string_lookup.f -----
+incdir+design
design/amf0ol_pkg.sv
design/amf0ol_key_regs.sv
design/amf0ol_parser.sv
design/amf0ol_out_reg.sv
design/amf0_object_string_lookup.sv
test/amf0_object_string_lookup_tb.sv
